>>> design/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 5;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  read_value;
    logic [ENTRY_W-1:0] entry_count;
    logic               table_full;
  } result_t;

endpackage

`default_nettype wire

>>> design/lkv_ram.sv
`default_nettype none

module lkv_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int WORD_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/lkv_ctrl.sv
`default_nettype none

module lkv_ctrl
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // request side
  input  wire logic              req_valid,
  output logic                   req_busy,
  input  wire logic [1:0]        req_mode,
  input  wire logic [DATA_W-1:0] req_key,
  input  wire logic [DATA_W-1:0] req_wval,
  // result side
  output logic                   res_valid,
  input  wire logic              res_ready,
  output result_t                res,
  // store ports
  output logic                   rd_en,
  output logic      [IDX_W-1:0]  rd_addr,
  input  wire logic [DATA_W-1:0] key_rdata,
  input  wire logic [DATA_W-1:0] val_rdata,
  output logic                   wr_key_en,
  output logic                   wr_val_en,
  output logic      [IDX_W-1:0]  wr_addr,
  output logic      [DATA_W-1:0] wr_key,
  output logic      [DATA_W-1:0] wr_val
);

  localparam int PX_W = CNT_W + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state, state_next;
  logic [1:0]        mode_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] wval_r;
  logic [IDX_W-1:0]  ptr, ptr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              res_hit, res_hit_next;
  logic [DATA_W-1:0] res_rval, res_rval_next;
  logic              res_full, res_full_next;

  logic [1:0]        cur_mode;
  logic [DATA_W-1:0] cur_key;
  logic [DATA_W-1:0] cur_wval;
  logic              accept;
  logic [PX_W-1:0]   ptr_ext;
  logic [PX_W-1:0]   cnt_ext;
  logic              match;
  logic              last;
  logic              do_miss;

  assign accept   = req_valid && (state == S_IDLE);
  assign req_busy = (state != S_IDLE);

  assign cur_mode = (state == S_IDLE) ? req_mode : mode_r;
  assign cur_key  = (state == S_IDLE) ? req_key  : key_r;
  assign cur_wval = (state == S_IDLE) ? req_wval : wval_r;

  assign ptr_ext = PX_W'(ptr);
  assign cnt_ext = PX_W'(count);
  assign match   = (key_rdata == key_r);
  assign last    = !((ptr_ext + PX_W'(1)) < cnt_ext);

  // a miss is settled either straight away on an empty table or at the end of a scan
  assign do_miss = (accept && (req_mode != MODE_CLEAR) && (count == '0)) ||
                   ((state == S_SCAN) && !match && last);

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    count_next    = count;
    res_hit_next  = res_hit;
    res_rval_next = res_rval;
    res_full_next = res_full;
    rd_en         = 1'b0;
    rd_addr       = ptr;
    wr_key_en     = 1'b0;
    wr_val_en     = 1'b0;
    wr_addr       = ptr;
    wr_key        = cur_key;
    wr_val        = cur_wval;

    if (do_miss) begin
      res_hit_next  = 1'b0;
      res_rval_next = '0;
      res_full_next = 1'b0;
      state_next    = S_DONE;
      if (cur_mode == MODE_SET) begin
        if (count < CNT_W'(ENTRIES)) begin
          wr_key_en  = 1'b1;
          wr_val_en  = 1'b1;
          wr_addr    = IDX_W'(count);
          count_next = count + CNT_W'(1);
        end else begin
          res_full_next = 1'b1;
        end
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_hit_next  = 1'b0;
            res_rval_next = '0;
            res_full_next = 1'b0;
            if (req_mode == MODE_CLEAR) begin
              count_next = '0;
              state_next = S_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            res_hit_next = 1'b1;
            state_next   = S_DONE;
            case (mode_r)
              MODE_SET: begin
                wr_val_en = 1'b1;
                wr_addr   = ptr;
              end
              MODE_GET: begin
                res_rval_next = val_rdata;
              end
              MODE_DELETE: begin
                if (last) begin
                  count_next = count - CNT_W'(1);
                end else begin
                  rd_en      = 1'b1;
                  rd_addr    = IDX_W'(ptr_ext + PX_W'(1));
                  state_next = S_SHIFT;
                end
              end
              default: begin
              end
            endcase
          end else begin
            rd_en    = 1'b1;
            rd_addr  = IDX_W'(ptr_ext + PX_W'(1));
            ptr_next = IDX_W'(ptr_ext + PX_W'(1));
          end
        end
        S_SHIFT: begin
          // slot ptr takes the pair read from ptr+1 last cycle
          wr_key_en = 1'b1;
          wr_val_en = 1'b1;
          wr_addr   = ptr;
          wr_key    = key_rdata;
          wr_val    = val_rdata;
          ptr_next  = IDX_W'(ptr_ext + PX_W'(1));
          if ((ptr_ext + PX_W'(2)) < cnt_ext) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(ptr_ext + PX_W'(2));
          end else begin
            count_next = count - CNT_W'(1);
            state_next = S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_next = S_IDLE;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= req_mode;
      key_r  <= req_key;
      wval_r <= req_wval;
    end
    ptr      <= ptr_next;
    res_hit  <= res_hit_next;
    res_rval <= res_rval_next;
    res_full <= res_full_next;
  end

  assign res_valid       = (state == S_DONE);
  assign res.hit         = res_hit;
  assign res.read_value  = res_rval;
  assign res.entry_count = ENTRY_W'(count);
  assign res.table_full  = res_full;

endmodule

`default_nettype wire

>>> design/linear_key_value_table_core.sv
// Linear key-value table: a packed, unsorted list of up to ENTRIES key/value
// pairs held in two single-port-read block memories and searched from slot 0.
// Input channel (in_valid/in_stall): mode (set, get, delete, clear), key and
// write_value. Output channel (out_valid/out_stall): hit, read_value,
// entry_count and table_full, one beat per request.
// One request is in flight at a time; in_stall is high while it is worked on.
// Clear, or any request on an empty table, is settled without a scan; other
// requests scan from slot 0 until a hit or until the last entry misses, and a
// delete hit then moves each later pair down one slot. The scan reads one
// slot per cycle through the memory read port. The controller takes the next
// request in the cycle after it hands its result on. The result sits in an
// output register, so the next request is taken while an earlier result is
// still stalled; a further result waits inside the controller and holds
// in_stall high until the output register frees.
// Reset empties the table (entry count zero) and drops any pending beat; the
// memories need no clearing since only slots below the count are ever read.
`default_nettype none

module linear_key_value_table_core
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          mode,
  input  wire logic signed [31:0]  key,
  input  wire logic [31:0]         write_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     hit,
  output logic [31:0]              read_value,
  output logic [4:0]               entry_count,
  output logic                     table_full
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] key_rdata;
  logic [DATA_W-1:0] val_rdata;
  logic              wr_key_en;
  logic              wr_val_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_key;
  logic [DATA_W-1:0] wr_val;

  assign res_ready = !out_valid || !out_stall;

  lkv_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_busy  (in_stall),
    .req_mode  (mode),
    .req_key   ($unsigned(key)),
    .req_wval  (write_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .key_rdata (key_rdata),
    .val_rdata (val_rdata),
    .wr_key_en (wr_key_en),
    .wr_val_en (wr_val_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_val    (wr_val)
  );

  lkv_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W),
    .WORD_W (DATA_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (wr_key_en),
    .waddr (wr_addr),
    .wdata (wr_key),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  lkv_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W),
    .WORD_W (DATA_W)
  ) u_val_ram (
    .clk   (clk),
    .we    (wr_val_en),
    .waddr (wr_addr),
    .wdata (wr_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      hit         <= res.hit;
      read_value  <= res.read_value;
      entry_count <= res.entry_count;
      table_full  <= res.table_full;
    end
  end

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !hit && (read_value == '0))
    else $error("dropped set reported a hit or a value");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_value != '0) |-> hit)
    else $error("non-zero read value without a hit");

  a_res_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while output register busy");
`endif

endmodule

`default_nettype wire
